@@ hw/rtl/glyph_texture_cache_lookup_unit_macros.svh @@
// Assertion macros for the glyph texture cache lookup unit.
// Used by the top level only; no other dependencies.
`ifndef GLYPH_TEXTURE_CACHE_LOOKUP_UNIT_MACROS_SVH
`define GLYPH_TEXTURE_CACHE_LOOKUP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define GTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtc assertion failed");
`define GTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtc assertion failed");
`else
`define GTC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/gtc_pkg.sv @@
// Package for the glyph texture cache lookup unit: sizes, codes, beat types.
// No dependencies.
package gtc_pkg;

    localparam int ENTRIES = 128;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = 8;
    localparam int TAG_W   = 64;

    localparam logic CMD_LOOKUP    = 1'b0;
    localparam logic CMD_NEW_FRAME = 1'b1;

    localparam logic [SLOT_W-1:0] FULL_SLOT = SLOT_W'(ENTRIES);

    typedef struct packed {
        logic        command;
        logic [15:0] glyph_number;
        logic [15:0] palette_number;
        logic [31:0] palette_generation;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              allocated;
        logic              full_res;
    } rsp_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [TAG_W-1:0] data;
    } tag_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/gtc_tag_ram.sv @@
// Tag store: ENTRIES x 64-bit synchronous RAM, one write and one read port,
// registered read data. Depends on gtc_pkg.
module gtc_tag_ram
    import gtc_pkg::*;
(
    input  logic             clk,
    input  tag_wr_t          wr,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [TAG_W-1:0] rd_data
);

    logic [TAG_W-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/glyph_texture_cache_lookup_unit.sv @@
// Glyph texture cache lookup unit: top level, scan control, use marks.
// Depends on gtc_pkg, gtc_tag_ram and the assertion macro header.
//
//   channel | dir | handshake        | beat
//   req     | in  | req_valid/stall  | req_t: command, glyph, palette, generation
//   rsp     | out | rsp_valid/stall  | rsp_t: slot, hit, allocated, full_res
//
// A lookup reads the tag RAM one entry a cycle and compares the registered
// read data, stopping at the first hit or after the last of the ENTRIES entries.
// A new frame skips the scan. One request is in flight at a time.
// Use marks and valid bits are flops cleared by reset; the tag RAM is not.
// A stalled response holds the unit in its final state; effects land
// when the response register is loaded.
`include "glyph_texture_cache_lookup_unit_macros.svh"

module glyph_texture_cache_lookup_unit
    import gtc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t state_reg, state_next;

    req_t             req_reg;
    logic [TAG_W-1:0] req_tag;

    logic [CNT_W-1:0] issue_cnt_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] used_reg;

    logic             out_valid_reg;
    rsp_t             out_reg;
    rsp_t             result;

    logic             accept;
    logic             issue;
    logic             cmp_hit;
    logic             cmp_last;
    logic             done_fire;
    logic [TAG_W-1:0] rd_data;
    tag_wr_t          tag_wr;

    assign req_tag   = {req_reg.palette_generation, req_reg.palette_number,
                        req_reg.glyph_number};
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    gtc_tag_ram u_tag_ram (
        .clk     (clk),
        .wr      (tag_wr),
        .rd_addr (issue_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Outputs of the sequencer
    always_comb
    begin
        req_stall = (state_reg != ST_IDLE);
        accept    = (state_reg == ST_IDLE) && req_valid;
        issue     = (state_reg == ST_SCAN) && (issue_cnt_reg < CNT_W'(ENTRIES));
        cmp_hit   = (state_reg == ST_SCAN) && cmp_vld_reg && valid_reg[cmp_idx_reg]
                    && (rd_data == req_tag);
        cmp_last  = (state_reg == ST_SCAN) && cmp_vld_reg
                    && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
        done_fire = (state_reg == ST_DONE) && (!out_valid_reg || !rsp_stall);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req.command == CMD_NEW_FRAME) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_hit || cmp_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result of the finished request
    always_comb
    begin
        result = '0;
        if (req_reg.command == CMD_NEW_FRAME)
        begin
            result = '0;
        end
        else if (hit_found_reg)
        begin
            result.slot = SLOT_W'(hit_idx_reg);
            result.hit  = 1'b1;
        end
        else if (free_found_reg)
        begin
            result.slot      = SLOT_W'(free_idx_reg);
            result.allocated = 1'b1;
        end
        else
        begin
            result.slot     = FULL_SLOT;
            result.full_res = 1'b1;
        end
    end

    always_comb
    begin
        tag_wr.en   = done_fire && (req_reg.command == CMD_LOOKUP)
                      && !hit_found_reg && free_found_reg;
        tag_wr.addr = free_idx_reg;
        tag_wr.data = req_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    // Scan pipeline: read issue, then compare in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else if (accept)
        begin
            issue_cnt_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            cmp_vld_reg <= issue;
            cmp_idx_reg <= issue_cnt_reg[IDX_W-1:0];
            if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            if (cmp_hit)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= cmp_idx_reg;
            end
            // lowest entry not yet used this frame
            if (cmp_vld_reg && !used_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
        end
        else if (done_fire)
        begin
            if (req_reg.command == CMD_NEW_FRAME)
            begin
                used_reg <= '0;
            end
            else if (hit_found_reg)
            begin
                used_reg[hit_idx_reg] <= 1'b1;
            end
            else if (free_found_reg)
            begin
                used_reg[free_idx_reg]  <= 1'b1;
                valid_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            out_reg <= result;
        end
    end

    `GTC_ASSERT_IMPL(a_one_outcome, clk, rst_n, out_valid_reg, $onehot0({out_reg.hit, out_reg.allocated, out_reg.full_res}))
    `GTC_ASSERT_IMPL(a_full_slot, clk, rst_n, out_valid_reg && out_reg.full_res, out_reg.slot == FULL_SLOT)
    `GTC_ASSERT_NEXT(a_alloc_marks, clk, rst_n, tag_wr.en, valid_reg[$past(tag_wr.addr)] && used_reg[$past(tag_wr.addr)])

endmodule

@@ sim/tb_glyph_texture_cache_lookup_unit.sv @@
// Self-checking testbench for glyph_texture_cache_lookup_unit: a shadow copy of the tag table
// predicts every lookup and new-frame beat. Depends on gtc_pkg and the unit's RTL only.
module tb_glyph_texture_cache_lookup_unit
    import gtc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1300;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    glyph_texture_cache_lookup_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow of the cache contents
    logic [TAG_W-1:0] shadow_tag [ENTRIES];
    bit shadow_valid [ENTRIES];
    bit shadow_used [ENTRIES];

    req_t req_backlog [$];
    rsp_t pending_answers [$];
    logic [TAG_W-1:0] recent_keys [$];

    int errors = 0;
    int answers_seen = 0;
    int quiet_cycles = 0;
    logic req_fire = 1'b0;

    int burst_left = 1;
    int gap_left = 0;
    int stall_mode = 0;
    int phase_left = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    function automatic rsp_t cache_answer(req_t r);
        logic [TAG_W-1:0] key;
        int pick;
        int spare;
        rsp_t a;
        key = {r.palette_generation, r.palette_number, r.glyph_number};
        a = '0;
        pick = -1;
        spare = -1;
        if (r.command == CMD_NEW_FRAME)
        begin
            for (int i = 0; i < ENTRIES; i++)
                shadow_used[i] = 1'b0;
            return a;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (pick < 0 && shadow_valid[i] && shadow_tag[i] == key)
                pick = i;
            if (spare < 0 && !shadow_used[i])
                spare = i;
        end
        if (pick >= 0)
        begin
            a.slot = SLOT_W'(pick);
            a.hit = 1'b1;
            shadow_used[pick] = 1'b1;
        end
        else if (spare >= 0)
        begin
            // may evict a valid entry left unused this frame
            a.slot = SLOT_W'(spare);
            a.allocated = 1'b1;
            shadow_tag[spare] = key;
            shadow_valid[spare] = 1'b1;
            shadow_used[spare] = 1'b1;
        end
        else
        begin
            a.slot = FULL_SLOT;
            a.full_res = 1'b1;
        end
        return a;
    endfunction

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    task automatic add_lookup(logic [TAG_W-1:0] key);
        req_t r;
        r.command = CMD_LOOKUP;
        r.glyph_number = key[15:0];
        r.palette_number = key[31:16];
        r.palette_generation = key[63:32];
        req_backlog.push_back(r);
        recent_keys.push_back(key);
        if (recent_keys.size() > 200)
            void'(recent_keys.pop_front());
    endtask

    task automatic add_new_frame();
        req_t r;
        // payload is ignored for a new frame; keep it busy anyway
        r = {1'b0, $urandom, $urandom};
        r.command = CMD_NEW_FRAME;
        req_backlog.push_back(r);
    endtask

    function automatic logic [TAG_W-1:0] fresh_key();
        logic [TAG_W-1:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: k[15:0] = '1;
            1: k[31:16] = '0;
            2: k[63:32] = '1;
            3: k[15:0] = '0;
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [TAG_W-1:0] altered_key(logic [TAG_W-1:0] k);
        logic [TAG_W-1:0] m;
        m = k;
        case ($urandom_range(0, 3))
            0: m[63:32] = m[63:32] + 32'd1;    // palette row rebuilt
            1: m[$urandom_range(0, 63)] = ~m[$urandom_range(0, 63)];
            2: m[31:16] = 16'($urandom);
            default: m[15:0] = 16'($urandom);
        endcase
        return m;
    endfunction

    // stimulus: directed opening, then frames of random lookups
    initial
    begin
        int frame_len;
        bit flood;
        bit first_frame;
        int total_items;
        add_lookup(64'h0);
        add_lookup(64'h0);                           // hit on an entry already used
        add_lookup('1);
        add_lookup('1);
        add_lookup(64'hFFFF_FFFE_FFFF_FFFF);         // generation differs only
        add_lookup(64'hFFFF_FFFF_7FFF_FFFF);         // palette differs only
        add_lookup(64'hFFFF_FFFF_FFFF_7FFF);         // glyph differs only
        add_lookup(64'h0000_0001_0000_0000);
        add_new_frame();
        add_lookup('1);
        add_lookup(64'h9ABC_DEF0_5678_1234);         // evicts the all-zero entry
        add_lookup(64'h0);
        add_lookup(64'h0000_0001_0000_0000);
        add_new_frame();
        add_new_frame();
        add_lookup(64'hA5A5_5A5A_5A5A_A5A5);
        add_lookup(64'h5A5A_A5A5_A5A5_5A5A);
        add_lookup(64'hA5A5_5A5A_5A5A_A5A5);

        first_frame = 1'b1;
        while (req_backlog.size() < ITEM_TARGET)
        begin
            add_new_frame();
            // flood frames run the table out of free entries
            flood = first_frame || ($urandom_range(0, 4) == 0);
            first_frame = 1'b0;
            frame_len = flood ? $urandom_range(130, 170) : $urandom_range(5, 70);
            for (int n = 0; n < frame_len; n++)
            begin
                int roll;
                roll = $urandom_range(0, 99);
                if (flood ? (roll < 80) : (roll < 35))
                    add_lookup(fresh_key());
                else if (roll < (flood ? 92 : 85))
                    add_lookup(recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
                else
                    add_lookup(altered_key(recent_keys[$urandom_range(0, recent_keys.size() - 1)]));
            end
        end
        total_items = req_backlog.size();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // one answer per beat; the watchdog covers a unit that stops answering
        while (answers_seen < total_items)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("** glyph_texture_cache_lookup_unit: PASSED **");
        else
            $display("** glyph_texture_cache_lookup_unit: FAILED **");
        $finish;
    end

    // request side: bursts of beats with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_fire))
        begin
            if (gap_left > 0 || req_backlog.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                req_valid <= 1'b0;
            end
            else
            begin
                req <= req_backlog.pop_front();
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left--;
            end
        end
    end

    // response side: stall pattern, plus one long hold-off so the input backs up
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            rsp_stall <= 1'b1;
        end
        else if (!holdoff_done && answers_seen >= 300)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 400);
            end
            else
                phase_left--;
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= 1'($urandom_range(0, 1));
                2: rsp_stall <= ($urandom_range(0, 3) != 0);
                default: rsp_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (!rst_n)
            req_fire <= 1'b0;
        else
        begin
            req_fire <= req_valid && !req_stall;
            if (rsp_valid && !rsp_stall)
            begin
                answers_seen <= answers_seen + 1;
                if (pending_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat, expected none, got slot %0d hit %0b alloc %0b full %0b",
                             $time, rsp.slot, rsp.hit, rsp.allocated, rsp.full_res);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    check_field("slot", want.slot, rsp.slot);
                    check_field("hit", 8'(want.hit), 8'(rsp.hit));
                    check_field("allocated", 8'(want.allocated), 8'(rsp.allocated));
                    check_field("full_res", 8'(want.full_res), 8'(rsp.full_res));
                end
            end
            if (req_valid && !req_stall)
                pending_answers.push_back(cache_answer(req));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** glyph_texture_cache_lookup_unit: FAILED **");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gtc_pkg.sv
hw/rtl/gtc_tag_ram.sv
hw/rtl/glyph_texture_cache_lookup_unit.sv
sim/tb_glyph_texture_cache_lookup_unit.sv
